// ===== rtl/ssm_pkg.sv =====
package ssm_pkg;

  // fixed widths of the channel fields
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned VALUE_W = 32;

  // function codes of a request
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FIRST  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_SECOND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH      = 2'd2;

  // classified command as it waits in the queue
  typedef enum logic [1:0] {
    OP_PUSH_A,
    OP_PUSH_B,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

// ===== rtl/ssm_req_if.sv =====
interface ssm_req_if;
  logic                         valid;
  logic                         ready;
  logic [ssm_pkg::FUNC_W-1:0]   func;
  logic signed [ssm_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

// ===== rtl/ssm_res_if.sv =====
interface ssm_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [ssm_pkg::VALUE_W-1:0] value_res;
  logic                               from_second;
  logic                               last;
  logic                               empty_res;
  logic                               overflow;

  modport source (output valid, output value_res, output from_second, output last,
                  output empty_res, output overflow, input ready);
  modport sink   (input valid, input value_res, input from_second, input last,
                  input empty_res, input overflow, output ready);
endinterface

// ===== rtl/sorted_sequence_merge.sv =====
// Two-way merge of sorted sequences. Push requests (func 0 and 1) append one
// signed element to the first or second store, one request per cycle while
// no merge is running, and give no result; a push into a full store is
// dropped and sets the overflow flag carried on the next run. A finish
// request (func 2) emits the merged run in non-decreasing order, first-store
// head only when strictly less, so ties come from the second store. The
// merge engine reads both store heads each cycle and emits the run while the
// output is not stalled; an empty finish gives one result with empty_res set.
// Requests pass through a two-entry command queue, so the input keeps taking
// requests while the output is stalled until that queue is full. Both stores
// and the flag are cleared at the end of each finish.
module sorted_sequence_merge #(
  parameter int unsigned LIST_DEPTH = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssm_req_if.sink    req_i,
  ssm_res_if.source  res_o
);

  logic          cmd_valid;
  ssm_pkg::cmd_t cmd;
  logic          cmd_pop;

  // request intake and command queue
  ssm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // stores and merge engine
  ssm_back #(
    .LIST_DEPTH (LIST_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/ssm_front.sv =====
module ssm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ssm_req_if.sink         req_i,
  output logic            cmd_valid_o,
  output ssm_pkg::cmd_t   cmd_o,
  input  logic            cmd_pop_i
);

  localparam int unsigned QDepth = 2;

  ssm_pkg::cmd_t     queue_q [QDepth];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;
  ssm_pkg::cmd_t     cmd_new;
  logic              keep;
  logic              push;
  logic              pop;

  // classify the request; unused code is taken and dropped
  always_comb begin
    cmd_new.value = req_i.value;
    cmd_new.op    = ssm_pkg::OP_FINISH;
    keep          = 1'b1;
    case (req_i.func)
      ssm_pkg::FUNC_PUSH_FIRST:  cmd_new.op = ssm_pkg::OP_PUSH_A;
      ssm_pkg::FUNC_PUSH_SECOND: cmd_new.op = ssm_pkg::OP_PUSH_B;
      ssm_pkg::FUNC_FINISH:      cmd_new.op = ssm_pkg::OP_FINISH;
      default:                   keep = 1'b0;
    endcase
  end

  assign req_i.ready = (cnt_q != 2'(QDepth));
  assign push        = req_i.valid && req_i.ready && keep;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];

  // queue pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== rtl/ssm_back.sv =====
module ssm_back #(
  parameter int unsigned LIST_DEPTH = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  ssm_pkg::cmd_t   cmd_i,
  output logic            cmd_pop_o,
  ssm_res_if.source       res_o
);

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IdxW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned ExtW = 64;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  state_e                       state_q, state_d;
  logic [CntW-1:0]              ca_q, ca_d, cb_q, cb_d;
  logic [CntW-1:0]              ia_q, ia_d, ib_q, ib_d;
  logic                         drop_q, drop_d;
  logic signed [DATA_WIDTH-1:0] mem_a [LIST_DEPTH];
  logic signed [DATA_WIDTH-1:0] mem_b [LIST_DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_a_q, rd_b_q;
  logic                         wr_a, wr_b;
  logic signed [ExtW-1:0]       in_ext;
  logic signed [DATA_WIDTH-1:0] elem_in;
  logic signed [DATA_WIDTH-1:0] chosen;
  logic signed [ExtW-1:0]       out_ext;
  logic                         take_first;
  logic [CntW:0]                done_cnt;
  logic [CntW:0]                total;
  logic                         is_last;
  logic                         slot_free;

  logic                               out_valid_q, out_valid_d;
  logic signed [ssm_pkg::VALUE_W-1:0] value_q, value_d;
  logic                               second_q, second_d;
  logic                               last_q, last_d;
  logic                               empty_q, empty_d;
  logic                               ovf_q, ovf_d;

  // element conversion: sign-extend the request value, keep the element width
  assign in_ext  = ExtW'(signed'(cmd_i.value));
  assign elem_in = in_ext[DATA_WIDTH-1:0];

  // merge decision on the two registered heads, ties go to the second
  assign take_first = (ia_q < ca_q) && ((ib_q >= cb_q) || (rd_a_q < rd_b_q));
  assign chosen     = take_first ? rd_a_q : rd_b_q;
  assign out_ext    = ExtW'(chosen);
  assign done_cnt   = {1'b0, ia_q} + {1'b0, ib_q} + (CntW + 1)'(1);
  assign total      = {1'b0, ca_q} + {1'b0, cb_q};
  assign is_last    = (done_cnt == total);
  assign slot_free  = !out_valid_q || res_o.ready;

  // command execution and merge sequencing
  always_comb begin
    state_d     = state_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    drop_d      = drop_q;
    cmd_pop_o   = 1'b0;
    wr_a        = 1'b0;
    wr_b        = 1'b0;
    out_valid_d = slot_free ? 1'b0 : out_valid_q;
    value_d     = value_q;
    second_d    = second_q;
    last_d      = last_q;
    empty_d     = empty_q;
    ovf_d       = ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            ssm_pkg::OP_PUSH_A: begin
              cmd_pop_o = 1'b1;
              if (ca_q == CntW'(LIST_DEPTH)) begin
                drop_d = 1'b1;
              end else begin
                wr_a = 1'b1;
                ca_d = ca_q + CntW'(1);
              end
            end
            ssm_pkg::OP_PUSH_B: begin
              cmd_pop_o = 1'b1;
              if (cb_q == CntW'(LIST_DEPTH)) begin
                drop_d = 1'b1;
              end else begin
                wr_b = 1'b1;
                cb_d = cb_q + CntW'(1);
              end
            end
            ssm_pkg::OP_FINISH: begin
              if (total == '0) begin
                if (slot_free) begin
                  cmd_pop_o   = 1'b1;
                  out_valid_d = 1'b1;
                  value_d     = '0;
                  second_d    = 1'b0;
                  last_d      = 1'b1;
                  empty_d     = 1'b1;
                  ovf_d       = drop_q;
                  drop_d      = 1'b0;
                end
              end else begin
                cmd_pop_o = 1'b1;
                ia_d      = '0;
                ib_d      = '0;
                state_d   = ST_MERGE;
              end
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      ST_MERGE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          value_d     = out_ext[ssm_pkg::VALUE_W-1:0];
          second_d    = !take_first;
          last_d      = is_last;
          empty_d     = 1'b0;
          ovf_d       = drop_q;
          if (take_first) begin
            ia_d = ia_q + CntW'(1);
          end else begin
            ib_d = ib_q + CntW'(1);
          end
          if (is_last) begin
            ca_d    = '0;
            cb_d    = '0;
            ia_d    = '0;
            ib_d    = '0;
            drop_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ca_q        <= '0;
      cb_q        <= '0;
      ia_q        <= '0;
      ib_q        <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ca_q        <= ca_d;
      cb_q        <= cb_d;
      ia_q        <= ia_d;
      ib_q        <= ib_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    second_q <= second_d;
    last_q   <= last_d;
    empty_q  <= empty_d;
    ovf_q    <= ovf_d;
  end

  // element stores; heads are read at the next index so they track ia_q and ib_q
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[ca_q[IdxW-1:0]] <= elem_in;
    end
    if (wr_b) begin
      mem_b[cb_q[IdxW-1:0]] <= elem_in;
    end
    rd_a_q <= mem_a[ia_d[IdxW-1:0]];
    rd_b_q <= mem_b[ib_d[IdxW-1:0]];
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.value_res   = value_q;
  assign res_o.from_second = second_q;
  assign res_o.last        = last_q;
  assign res_o.empty_res   = empty_q;
  assign res_o.overflow    = ovf_q;

endmodule

// ===== rtl/ssm_checker.sv =====
module ssm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic signed [ssm_pkg::VALUE_W-1:0] value_res,
  input logic                               from_second,
  input logic                               last,
  input logic                               empty_res,
  input logic                               overflow
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> ($stable(value_res) && $stable(last) &&
      $stable(from_second) && $stable(empty_res) && $stable(overflow)))
    else $error("result payload changed while stalled");

  // the empty marker is a lone zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && empty_res) |-> (last && !from_second && value_res == '0))
    else $error("malformed empty result");

  // a run continues in the next cycle with the same overflow flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready && !last) |=>
      (res_valid && !empty_res && overflow == $past(overflow)))
    else $error("merged run broken or overflow flag changed");

endmodule

bind sorted_sequence_merge ssm_checker u_ssm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid   (res_o.valid),
  .res_ready   (res_o.ready),
  .value_res   (res_o.value_res),
  .from_second (res_o.from_second),
  .last        (res_o.last),
  .empty_res   (res_o.empty_res),
  .overflow    (res_o.overflow)
);

// ===== test/sorted_sequence_merge_tb.sv =====
module sorted_sequence_merge_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH  = 32;
  localparam int unsigned ELEM_W = 32;

  // code 3 is not decoded by the block
  localparam logic [ssm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [ssm_pkg::FUNC_W-1:0]         func;
    logic signed [ssm_pkg::VALUE_W-1:0] value;
  } merge_req_t;

  typedef struct {
    logic signed [ssm_pkg::VALUE_W-1:0] value;
    logic                               from_second;
    logic                               last;
    logic                               is_empty;
    logic                               overflow;
  } merged_elem_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ssm_req_if req_if ();
  ssm_res_if res_if ();

  sorted_sequence_merge #(
    .LIST_DEPTH(DEPTH),
    .DATA_WIDTH(ELEM_W)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  // clock
  always #5 clk_i = ~clk_i;

  merge_req_t   pending_reqs[$];
  merged_elem_t merged_expect[$];

  // mirror of the two stores
  logic signed [ssm_pkg::VALUE_W-1:0] first_mem [DEPTH];
  logic signed [ssm_pkg::VALUE_W-1:0] second_mem[DEPTH];
  int                                 first_len;
  int                                 second_len;
  logic                               drop_seen;

  int idle_pct;
  int stall_pct;
  int hold_len;
  int err_count;

  // sign-extend the pushed value from the element width
  function automatic logic signed [ssm_pkg::VALUE_W-1:0] to_elem(
      logic signed [ssm_pkg::VALUE_W-1:0] raw);
    return (raw <<< (ssm_pkg::VALUE_W - ELEM_W)) >>> (ssm_pkg::VALUE_W - ELEM_W);
  endfunction

  // update the mirror with one accepted request, queue the merged run on finish
  function automatic void predict_merge(logic [ssm_pkg::FUNC_W-1:0] func,
                                        logic signed [ssm_pkg::VALUE_W-1:0] value);
    int           i;
    int           j;
    int           k;
    int           total;
    logic         take_first;
    merged_elem_t elem;
    i = 0;
    j = 0;
    k = 0;
    case (func)
      ssm_pkg::FUNC_PUSH_FIRST: begin
        if (first_len < DEPTH) begin
          first_mem[first_len] = to_elem(value);
          first_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      ssm_pkg::FUNC_PUSH_SECOND: begin
        if (second_len < DEPTH) begin
          second_mem[second_len] = to_elem(value);
          second_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      ssm_pkg::FUNC_FINISH: begin
        total = first_len + second_len;
        elem.overflow = drop_seen;
        elem.is_empty = 1'b0;
        if (total == 0) begin
          elem.value       = '0;
          elem.from_second = 1'b0;
          elem.last        = 1'b1;
          elem.is_empty    = 1'b1;
          merged_expect.push_back(elem);
        end
        // ties go to the second store
        while (i < first_len || j < second_len) begin
          if (i >= first_len) begin
            take_first = 1'b0;
          end else if (j >= second_len) begin
            take_first = 1'b1;
          end else begin
            take_first = first_mem[i] < second_mem[j];
          end
          if (take_first) begin
            elem.value = first_mem[i];
            i++;
          end else begin
            elem.value = second_mem[j];
            j++;
          end
          elem.from_second = !take_first;
          elem.last        = (k + 1 == total);
          merged_expect.push_back(elem);
          k++;
        end
        first_len  = 0;
        second_len = 0;
        drop_seen  = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic add_req(logic [ssm_pkg::FUNC_W-1:0] func,
                         logic signed [ssm_pkg::VALUE_W-1:0] value);
    merge_req_t r;
    r.func  = func;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  // value mixes: full range, narrow range with many ties, extremes
  function automatic int pick_value(int mode);
    int sel;
    sel = $urandom_range(0, 4);
    case (mode)
      0: return $urandom();
      1: return int'($urandom_range(0, 6)) - 3;
      default: begin
        case (sel)
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 0;
          3: return -1;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // one run: pushes to both stores, interleaved with an occasional unused code, then a finish
  task automatic add_merge_run();
    int first_vals[$];
    int second_vals[$];
    int n_first;
    int n_second;
    int mode;
    int sel;
    sel  = $urandom_range(0, 99);
    mode = $urandom_range(0, 2);
    if (sel < 6) begin
      // overfill one store
      n_first  = $urandom_range(0, 4);
      n_second = $urandom_range(0, 4);
      if ($urandom_range(0, 1)) n_first = $urandom_range(DEPTH + 1, DEPTH + 3);
      else n_second = $urandom_range(DEPTH + 1, DEPTH + 3);
    end else if (sel < 12) begin
      n_first  = $urandom_range(20, DEPTH);
      n_second = $urandom_range(20, DEPTH);
    end else begin
      n_first  = $urandom_range(0, 6);
      n_second = $urandom_range(0, 6);
    end
    repeat (n_first) first_vals.push_back(pick_value(mode));
    repeat (n_second) second_vals.push_back(pick_value(mode));
    // most runs are sorted, a few are left as drawn
    if ($urandom_range(0, 9) != 0) begin
      first_vals.sort();
      second_vals.sort();
    end
    while (first_vals.size() > 0 || second_vals.size() > 0) begin
      if (second_vals.size() == 0 || (first_vals.size() > 0 && $urandom_range(0, 1))) begin
        add_req(ssm_pkg::FUNC_PUSH_FIRST, first_vals.pop_front());
      end else begin
        add_req(ssm_pkg::FUNC_PUSH_SECOND, second_vals.pop_front());
      end
      if ($urandom_range(0, 19) == 0) add_req(FUNC_UNUSED, $urandom());
    end
    add_req(ssm_pkg::FUNC_FINISH, $urandom());
  endtask

  task automatic check_field(string name, logic [ssm_pkg::VALUE_W-1:0] expected,
                             logic [ssm_pkg::VALUE_W-1:0] actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
      err_count++;
    end
  endtask

  // request driver, predicts on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) predict_merge(req_if.func, req_if.value);
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          req_if.valid <= 1'b1;
          req_if.func  <= pending_reqs[0].func;
          req_if.value <= pending_reqs[0].value;
          void'(pending_reqs.pop_front());
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_len > 0) hold_len <= hold_len - 1;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (merged_expect.size() == 0) begin
          $error("unexpected result: value_res %0h", res_if.value_res);
          err_count++;
        end else begin
          check_field("value_res", merged_expect[0].value, res_if.value_res);
          check_field("from_second", merged_expect[0].from_second, res_if.from_second);
          check_field("last", merged_expect[0].last, res_if.last);
          check_field("empty_res", merged_expect[0].is_empty, res_if.empty_res);
          check_field("overflow", merged_expect[0].overflow, res_if.overflow);
          void'(merged_expect.pop_front());
        end
      end
      res_if.ready <= (hold_len == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // run time limit
  initial begin
    #(10_000_000);
    $display("Verification failed");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int idle_tbl[4];
    int stall_tbl[4];
    int ph;
    int target;
    idle_tbl  = '{0, 86, 0, 18};
    stall_tbl = '{0, 0, 86, 18};
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.func  = ssm_pkg::FUNC_PUSH_FIRST;
    req_if.value = '0;
    res_if.ready = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_len     = 0;
    err_count    = 0;
    first_len    = 0;
    second_len   = 0;
    drop_seen    = 1'b0;

    // both stores empty
    add_req(ssm_pkg::FUNC_FINISH, $urandom());
    // extremes in both stores, with ties across them
    add_req(ssm_pkg::FUNC_PUSH_FIRST, 32'h8000_0000);
    add_req(ssm_pkg::FUNC_PUSH_FIRST, 32'h0000_0000);
    add_req(ssm_pkg::FUNC_PUSH_FIRST, 32'h7fff_ffff);
    add_req(ssm_pkg::FUNC_PUSH_SECOND, 32'h8000_0000);
    add_req(ssm_pkg::FUNC_PUSH_SECOND, 32'h0000_0000);
    add_req(ssm_pkg::FUNC_PUSH_SECOND, 32'hffff_ffff);
    add_req(ssm_pkg::FUNC_PUSH_SECOND, 32'h7fff_ffff);
    add_req(ssm_pkg::FUNC_FINISH, 32'hffff_ffff);
    // only the second store filled
    add_req(ssm_pkg::FUNC_PUSH_SECOND, 32'sd5);
    add_req(ssm_pkg::FUNC_FINISH, 32'h0000_0000);
    // only the first store filled, equal elements
    add_req(ssm_pkg::FUNC_PUSH_FIRST, -32'sd7);
    add_req(ssm_pkg::FUNC_PUSH_FIRST, -32'sd7);
    add_req(ssm_pkg::FUNC_FINISH, 32'h5555_aaaa);
    // unused code changes nothing
    add_req(FUNC_UNUSED, 32'hffff_ffff);
    add_req(FUNC_UNUSED, 32'h0000_0000);
    add_req(ssm_pkg::FUNC_FINISH, 32'haaaa_5555);
    // unsorted first store
    add_req(ssm_pkg::FUNC_PUSH_FIRST, 32'sd10);
    add_req(ssm_pkg::FUNC_PUSH_FIRST, 32'sd3);
    add_req(ssm_pkg::FUNC_PUSH_SECOND, 32'sd5);
    add_req(ssm_pkg::FUNC_FINISH, 32'h0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idling and stalling phases
    for (ph = 0; ph < 4; ph++) begin
      idle_pct  <= idle_tbl[ph];
      stall_pct <= stall_tbl[ph];
      target = pending_reqs.size() + 40;
      while (pending_reqs.size() < target) add_merge_run();
      while (pending_reqs.size() > 0) @(posedge clk_i);
    end

    // receiver holds off while requests keep coming
    idle_pct  <= 0;
    stall_pct <= 0;
    repeat (6) add_merge_run();
    hold_len <= 200;
    while (pending_reqs.size() > 0 || req_if.valid) @(posedge clk_i);

    while (merged_expect.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ssm_pkg.sv
rtl/ssm_req_if.sv
rtl/ssm_res_if.sv
rtl/ssm_front.sv
rtl/ssm_back.sv
rtl/sorted_sequence_merge.sv
rtl/ssm_checker.sv
test/sorted_sequence_merge_tb.sv
